// ===== sv/dgr_pkg.sv =====
package dgr_pkg;

  localparam int SCREEN_WIDTH_D  = 640;
  localparam int SCREEN_HEIGHT_D = 480;
  localparam int GRID_WIDTH_D    = 32;
  localparam int GRID_HEIGHT_D   = 32;
  localparam int CELL_BITS_D     = 4;
  localparam int MAP_DEPTH       = 1024;
  localparam int MAP_AW          = 10;

  // configuration register indexes
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [9:0] cell_index;
    logic [3:0] cell_value;
    logic [9:0] screen_column;
  } dgr_in_t;

  typedef struct packed {
    logic [9:0] column_out;
    logic [8:0] span_top;
    logic [8:0] span_bottom;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       north_south_face;
    logic [3:0] wall_type;
    logic       left_grid;
  } dgr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CAM,
    ST_RAY,
    ST_DIVX,
    ST_DIVY,
    ST_SIDE,
    ST_STEP,
    ST_READ,
    ST_TEST,
    ST_HDIV,
    ST_DONE
  } dgr_state_t;

  // datapath commands
  typedef struct packed {
    logic clr_go;
    logic latch;
    logic cam;
    logic ray;
    logic div_x_go;
    logic div_y_go;
    logic side;
    logic step;
    logic hdiv_go;
    logic finish;
  } dgr_cmd_t;

  // datapath status
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic out_of_grid;
    logic cell_hit;
    logic walk_over;
    logic is_write;
  } dgr_sts_t;

endpackage

// ===== sv/dgr_ram.sv =====
module dgr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dgr_div.sv =====
module dgr_div #(
  parameter int NW = 42,
  parameter int DW = 42,
  parameter int QW = 42
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);
  localparam int RW = DW + 1;

  logic [NW-1:0] n_r, n_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [RW-1:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[RW-2:0], n_r[NW-1]};
    if (go) begin
      n_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        n_nxt   = {n_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        n_nxt   = {n_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign quo  = QW'(n_nxt);

endmodule

// ===== sv/dgr_datapath.sv =====
module dgr_datapath #(
  parameter int SCREEN_WIDTH  = dgr_pkg::SCREEN_WIDTH_D,
  parameter int SCREEN_HEIGHT = dgr_pkg::SCREEN_HEIGHT_D,
  parameter int GRID_WIDTH    = dgr_pkg::GRID_WIDTH_D,
  parameter int GRID_HEIGHT   = dgr_pkg::GRID_HEIGHT_D,
  parameter int CELL_BITS     = dgr_pkg::CELL_BITS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dgr_pkg::dgr_in_t  in_item,
  input  dgr_pkg::dgr_cmd_t cmd,
  input  logic [20:0]       pos_x,
  input  logic [20:0]       pos_y,
  input  logic [18:0]       dir_x,
  input  logic [18:0]       dir_y,
  input  logic [18:0]       plane_x,
  input  logic [18:0]       plane_y,
  output dgr_pkg::dgr_sts_t sts,
  output dgr_pkg::dgr_out_t result
);
  import dgr_pkg::*;

  localparam int HALF_H   = SCREEN_HEIGHT / 2;
  localparam int LH_MAX   = 2 * SCREEN_HEIGHT;
  localparam int LHW      = $clog2(LH_MAX + 1);
  localparam int SLIM     = GRID_WIDTH + GRID_HEIGHT + 2;
  localparam int SCW      = $clog2(SLIM + 1);
  localparam logic [41:0] DELTA_INF = 42'(64'd1 << 40);
  localparam logic [41:0] HNUM = 42'(64'(SCREEN_HEIGHT) * 64'd65536);
  // reciprocal of the screen width, exact for every 10-bit column
  localparam logic [38:0] CAM_RECIP =
    39'(((64'd1 << 39) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  // latched item and cast state
  logic [9:0]  col_r;
  logic [9:0]  ccol_r;
  logic [9:0]  idx_r;
  logic [3:0]  val_r;
  logic        isw_r;
  logic signed [17:0] cam_r;
  logic signed [20:0] rx_r, ry_r;
  logic [41:0] dx_r, dy_r;
  logic [47:0] sx_r, sy_r;
  logic signed [9:0] mx_r, my_r;
  logic        ns_r;
  logic [SCW-1:0] steps_r;
  logic [MAP_AW-1:0] clr_r;
  logic        clr_busy_r;
  logic        ram_clr;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      col_r  <= in_item.screen_column;
      ccol_r <= (32'(in_item.screen_column) >= SCREEN_WIDTH) ?
                10'(SCREEN_WIDTH - 1) : in_item.screen_column;
      idx_r  <= in_item.cell_index;
      val_r  <= in_item.cell_value & 4'((1 << CELL_BITS) - 1);
      isw_r  <= (in_item.cmd == CMD_WRITE);
    end
  end

  // camera x: floor(2*col*65536/W) - 65536 by reciprocal multiply
  logic [48:0] cam_prod;
  logic [26:0] cam_q;
  assign cam_prod = 49'(ccol_r) * 49'(CAM_RECIP);
  assign cam_q    = cam_prod[48:22];
  always_ff @(posedge clk) begin
    if (cmd.cam) begin
      cam_r <= 18'($signed({1'b0, cam_q}) - 29'sd65536);
    end
  end

  // plane times camera
  logic signed [36:0] px_c, py_c;
  assign px_c = $signed(plane_x) * cam_r;
  assign py_c = $signed(plane_y) * cam_r;

  logic signed [21:0] rx_c, ry_c;
  assign rx_c = 22'($signed(dir_x)) + 22'(px_c >>> 16);
  assign ry_c = 22'($signed(dir_y)) + 22'(py_c >>> 16);

  // shared divider for deltas and line height
  logic [41:0] dv_num, dv_q;
  logic [47:0] dv_den;
  logic        dv_go, dv_done;
  logic [20:0] abs_x, abs_y;
  assign abs_x = rx_r[20] ? 21'(-rx_r) : 21'(rx_r);
  assign abs_y = ry_r[20] ? 21'(-ry_r) : 21'(ry_r);
  logic [47:0] perp;
  assign perp = ns_r ? sy_r - 48'(dy_r) : sx_r - 48'(dx_r);

  always_comb begin
    dv_go  = cmd.div_x_go | cmd.div_y_go | cmd.hdiv_go;
    dv_num = cmd.hdiv_go ? HNUM : 42'(64'd1 << 32);
    dv_den = cmd.hdiv_go ? perp : (cmd.div_x_go ? 48'(abs_x) : 48'(abs_y));
  end

  dgr_div #(.NW(42), .DW(48), .QW(42)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (dv_go),
    .num  (dv_num),
    .den  (dv_den),
    .done (dv_done),
    .quo  (dv_q)
  );

  logic div_sel_y_r, div_h_r;
  always_ff @(posedge clk) begin
    if (cmd.ray) begin
      rx_r <= 21'(rx_c);
      ry_r <= 21'(ry_c);
    end
    if (cmd.div_x_go) div_sel_y_r <= 1'b0;
    if (cmd.div_y_go) div_sel_y_r <= 1'b1;
    if (cmd.div_x_go || cmd.div_y_go) div_h_r <= 1'b0;
    if (cmd.hdiv_go) div_h_r <= 1'b1;
  end

  // side distances, fractions to next grid line
  logic [16:0] fx, fy;
  assign fx = rx_r[20] ? {1'b0, pos_x[15:0]} : 17'(17'd65536 - {1'b0, pos_x[15:0]});
  assign fy = ry_r[20] ? {1'b0, pos_y[15:0]} : 17'(17'd65536 - {1'b0, pos_y[15:0]});
  logic [58:0] fsx, fsy;
  assign fsx = fx * dx_r;
  assign fsy = fy * dy_r;

  // map step
  logic step_x;
  assign step_x = sx_r < sy_r;
  logic signed [9:0] mx_n, my_n;
  assign mx_n = step_x ? (rx_r[20] ? mx_r - 10'sd1 : mx_r + 10'sd1) : mx_r;
  assign my_n = step_x ? my_r : (ry_r[20] ? my_r - 10'sd1 : my_r + 10'sd1);

  logic [LHW-1:0] lh_r;

  always_ff @(posedge clk) begin
    if (dv_done && !div_h_r) begin
      if (!div_sel_y_r) dx_r <= (rx_r == '0) ? DELTA_INF : dv_q;
      else              dy_r <= (ry_r == '0) ? DELTA_INF : dv_q;
    end
    if (cmd.side) begin
      sx_r    <= 48'(fsx >> 16);
      sy_r    <= 48'(fsy >> 16);
      mx_r    <= $signed({5'd0, pos_x[20:16]});
      my_r    <= $signed({5'd0, pos_y[20:16]});
      steps_r <= '0;
      ns_r    <= 1'b0;
    end
    if (cmd.step) begin
      if (step_x) sx_r <= sx_r + 48'(dx_r);
      else        sy_r <= sy_r + 48'(dy_r);
      mx_r    <= mx_n;
      my_r    <= my_n;
      ns_r    <= !step_x;
      steps_r <= steps_r + SCW'(1);
    end
    if (cmd.hdiv_go && perp == '0) begin
      lh_r <= LHW'(LH_MAX);
    end else if (dv_done && div_h_r) begin
      lh_r <= (dv_q > 42'(LH_MAX)) ? LHW'(LH_MAX) : LHW'(dv_q);
    end
  end

  // map memory with clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b0;
      clr_r      <= '0;
    end else if (cmd.clr_go) begin
      clr_busy_r <= 1'b1;
      clr_r      <= '0;
    end else if (clr_busy_r) begin
      clr_r <= clr_r + MAP_AW'(1);
      if (clr_r == MAP_AW'(MAP_DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end
  assign ram_clr = clr_busy_r;

  logic [MAP_AW-1:0] raddr;
  logic [31:0] ra_w;
  logic [3:0]  rdata;
  assign ra_w  = 32'($unsigned(my_r)) * 32'(GRID_WIDTH) + 32'($unsigned(mx_r));
  assign raddr = ra_w[MAP_AW-1:0];

  dgr_ram #(.WIDTH(4), .DEPTH(MAP_DEPTH)) u_map (
    .clk  (clk),
    .we   (ram_clr | cmd.finish & isw_r),
    .waddr(ram_clr ? clr_r : idx_r),
    .wdata(ram_clr ? 4'd0 : val_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.clr_done    = clr_busy_r && (clr_r == MAP_AW'(MAP_DEPTH - 1));
  assign sts.div_done    = dv_done;
  assign sts.out_of_grid = (mx_r < 0) || (32'(mx_r) >= GRID_WIDTH) ||
                           (my_r < 0) || (32'(my_r) >= GRID_HEIGHT);
  assign sts.cell_hit    = rdata != 4'd0;
  assign sts.walk_over   = steps_r >= SCW'(SLIM);
  assign sts.is_write    = isw_r;

  // result formation
  logic [7:0] r_c, g_c, b_c;
  logic [LHW-1:0] lh2;
  logic hit;
  assign hit = sts.cell_hit && !sts.out_of_grid;
  assign lh2 = lh_r >> 1;
  always_comb begin
    r_c = 8'd0; g_c = 8'd0; b_c = 8'd0;
    case (rdata)
      4'd1: r_c = 8'd255;
      4'd2: g_c = 8'd255;
      4'd3: b_c = 8'd255;
      4'd4: ;
      default: begin r_c = 8'd234; g_c = 8'd170; end
    endcase
    if (ns_r) begin
      r_c = r_c >> 1; g_c = g_c >> 1; b_c = b_c >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.column_out       <= col_r;
      result.north_south_face <= ns_r;
      result.left_grid        <= !hit;
      result.wall_type        <= hit ? rdata : 4'd0;
      result.red              <= hit ? r_c : 8'd0;
      result.green            <= hit ? g_c : 8'd0;
      result.blue             <= hit ? b_c : 8'd0;
      result.span_top         <= !hit ? 9'd0 :
        (32'(lh2) >= HALF_H ? 9'd0 : 9'(HALF_H - 32'(lh2)));
      result.span_bottom      <= !hit ? 9'd0 :
        (32'(lh2) + HALF_H >= SCREEN_HEIGHT ? 9'(SCREEN_HEIGHT) :
         9'(32'(lh2) + HALF_H));
    end
  end

endmodule

// ===== sv/dgr_ctrl.sv =====
module dgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dgr_pkg::dgr_sts_t sts,
  output dgr_pkg::dgr_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import dgr_pkg::*;

  dgr_state_t state_r, state_nxt;
  logic       hit_r, hit_nxt;
  logic       ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      hit_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // clear the map after reset, then sequence one command at a time through the datapath
  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    ov_nxt    = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        if (!hit_r) begin
          cmd.clr_go = 1'b1;
          hit_nxt    = 1'b1;
        end else if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_CAM;
        end
      end
      ST_CAM: begin
        if (sts.is_write) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.cam   = 1'b1;
          state_nxt = ST_RAY;
        end
      end
      ST_RAY: begin
        cmd.ray   = 1'b1;
        state_nxt = ST_DIVX;
        hit_nxt   = 1'b0;
      end
      ST_DIVX: begin
        if (!hit_r) begin
          cmd.div_x_go = 1'b1;
          hit_nxt      = 1'b1;
        end else if (sts.div_done) begin
          state_nxt = ST_DIVY;
          hit_nxt   = 1'b0;
        end
      end
      ST_DIVY: begin
        if (!hit_r) begin
          cmd.div_y_go = 1'b1;
          hit_nxt      = 1'b1;
        end else if (sts.div_done) begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        cmd.side  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (sts.out_of_grid || sts.walk_over && !sts.cell_hit) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.cell_hit) begin
          cmd.hdiv_go = 1'b1;
          hit_nxt     = 1'b0;
          state_nxt   = ST_HDIV;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_HDIV: begin
        if (sts.div_done || hit_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = ov_r;

  a_ov_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.finish)) else $error("strobe without finish");
  a_busy_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> busy) else $error("step while idle");
  a_start_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> cmd.latch) else $error("start not latched");

endmodule

// ===== sv/dda_grid_raycast_column.sv =====
// DDA grid raycaster, one screen column per command.
// Input: pulse start with in_item while busy is low. cmd 0 writes a map
// cell and gives no result; cmd 1 casts the ray for screen_column.
// Output: out_valid strobes one cycle with out_item; the receiver must
// take it then, it cannot stall the block.
// Config: APB port, register i at byte 4*i, pready always high.
// Sequence of a cast: camera and ray set-up, two reciprocal divisions,
// side distances, then the walk (steps up to 66), each walk step passing
// the STEP, READ and TEST states for the map read; on a wall hit a height
// division follows, while a ray that leaves the grid ends after TEST. The
// three divisions share one radix-2 divider. busy drops as out_valid
// rises, so the next start is taken in the strobe cycle.
// Reset: the map is swept to zero, busy high meanwhile; camera
// registers return to their reset values at once.
module dda_grid_raycast_column #(
  parameter int SCREEN_WIDTH  = dgr_pkg::SCREEN_WIDTH_D,
  parameter int SCREEN_HEIGHT = dgr_pkg::SCREEN_HEIGHT_D,
  parameter int GRID_WIDTH    = dgr_pkg::GRID_WIDTH_D,
  parameter int GRID_HEIGHT   = dgr_pkg::GRID_HEIGHT_D,
  parameter int CELL_BITS     = dgr_pkg::CELL_BITS_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dgr_pkg::dgr_in_t  in_item,
  output logic              out_valid,
  output dgr_pkg::dgr_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dgr_pkg::*;

  logic [20:0] pos_x_r, pos_y_r;
  logic [18:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [2:0]  ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= 21'd65536;
      pos_y_r   <= 21'd65536;
      dir_x_r   <= 19'd65536;
      dir_y_r   <= 19'd0;
      plane_x_r <= 19'd0;
      plane_y_r <= 19'd43253;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_POS_X:   pos_x_r   <= pwdata[20:0];
        REG_POS_Y:   pos_y_r   <= pwdata[20:0];
        REG_DIR_X:   dir_x_r   <= pwdata[18:0];
        REG_DIR_Y:   dir_y_r   <= pwdata[18:0];
        REG_PLANE_X: plane_x_r <= pwdata[18:0];
        REG_PLANE_Y: plane_y_r <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      REG_POS_X:   prdata = 32'(pos_x_r);
      REG_POS_Y:   prdata = 32'(pos_y_r);
      REG_DIR_X:   prdata = 32'(dir_x_r);
      REG_DIR_Y:   prdata = 32'(dir_y_r);
      REG_PLANE_X: prdata = 32'(plane_x_r);
      REG_PLANE_Y: prdata = 32'(plane_y_r);
      default:     prdata = 32'd0;
    endcase
  end

  dgr_cmd_t cmd;
  dgr_sts_t sts;

  dgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  dgr_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .GRID_WIDTH   (GRID_WIDTH),
    .GRID_HEIGHT  (GRID_HEIGHT),
    .CELL_BITS    (CELL_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_item(in_item),
    .cmd    (cmd),
    .pos_x  (pos_x_r),
    .pos_y  (pos_y_r),
    .dir_x  (dir_x_r),
    .dir_y  (dir_y_r),
    .plane_x(plane_x_r),
    .plane_y(plane_y_r),
    .sts    (sts),
    .result (out_item)
  );

endmodule

// ===== sim/tb_dda_grid_raycast_column.sv =====
module tb_dda_grid_raycast_column;
  timeunit 1ns;
  timeprecision 1ps;
  import dgr_pkg::*;

  localparam int SW = 640;
  localparam int SH = 480;
  localparam int GW = 32;
  localparam int GH = 32;
  localparam longint DELTA_INF = 64'd1 << 40;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dgr_in_t in_item = '0;
  logic out_valid;
  dgr_out_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dda_grid_raycast_column dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // camera copy and map copy for the predictor
  logic [20:0] cam_pos_x, cam_pos_y;
  logic signed [18:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  logic [3:0] grid_map [MAP_DEPTH];

  dgr_in_t pending_beats[$];
  dgr_out_t expected_columns[$];
  int send_idle_pct = 0;
  int mismatches = 0;
  longint cycles = 0;

  function automatic longint floor_div16(longint v);
    if (v >= 0) return v / 65536;
    return -((-v - 1) / 65536) - 1;
  endfunction

  // predict one cast from the camera copy and the map copy
  function automatic dgr_out_t cast_column(dgr_in_t it);
    dgr_out_t r;
    longint col, cam, rx, ry, dx, dy, sx, sy, fx, fy, perp, lh, top, bot;
    int mx, my, stx, sty;
    bit ns, left;
    logic [3:0] wt;
    logic [7:0] cr, cg, cb;
    ns = 0; left = 0; wt = 0; cr = 0; cg = 0; cb = 0;
    col = it.screen_column;
    if (col >= SW) col = SW - 1;
    cam = (2 * col * 65536) / SW - 65536;
    rx = longint'(cam_dir_x) + floor_div16(longint'(cam_plane_x) * cam);
    ry = longint'(cam_dir_y) + floor_div16(longint'(cam_plane_y) * cam);
    dx = (rx == 0) ? DELTA_INF : (64'd1 << 32) / (rx < 0 ? -rx : rx);
    dy = (ry == 0) ? DELTA_INF : (64'd1 << 32) / (ry < 0 ? -ry : ry);
    mx = cam_pos_x >> 16;
    my = cam_pos_y >> 16;
    fx = cam_pos_x & 16'hFFFF;
    fy = cam_pos_y & 16'hFFFF;
    if (rx < 0) stx = -1; else begin stx = 1; fx = 65536 - fx; end
    if (ry < 0) sty = -1; else begin sty = 1; fy = 65536 - fy; end
    sx = (fx * dx) >>> 16;
    sy = (fy * dy) >>> 16;
    for (int k = 0; k < GW + GH + 2; k++) begin
      if (sx < sy) begin
        sx += dx; mx += stx; ns = 0;
      end else begin
        sy += dy; my += sty; ns = 1;
      end
      if (mx < 0 || mx >= GW || my < 0 || my >= GH) begin
        left = 1;
        break;
      end
      wt = grid_map[(my * GW + mx) & (MAP_DEPTH - 1)];
      if (wt != 0) break;
    end
    if (!left && wt == 0) left = 1;
    top = 0; bot = 0;
    if (left) wt = 0;
    else begin
      perp = ns ? sy - dy : sx - dx;
      if (perp == 0) lh = 2 * SH;
      else begin
        lh = (longint'(SH) * 65536) / perp;
        if (lh > 2 * SH) lh = 2 * SH;
      end
      top = SH / 2 - lh / 2;
      if (top < 0) top = 0;
      bot = lh / 2 + SH / 2;
      if (bot >= SH) bot = SH;
      case (wt)
        1: cr = 255;
        2: cg = 255;
        3: cb = 255;
        4: ;
        default: begin cr = 234; cg = 170; end
      endcase
      if (ns) begin cr >>= 1; cg >>= 1; cb >>= 1; end
    end
    r.column_out = it.screen_column;
    r.span_top = top[8:0];
    r.span_bottom = bot[8:0];
    r.red = cr; r.green = cg; r.blue = cb;
    r.north_south_face = ns;
    r.wall_type = wt;
    r.left_grid = left;
    return r;
  endfunction

  // drive beats from the pending queue; predict at acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (start && !busy) begin
      if (in_item.cmd == CMD_WRITE) grid_map[in_item.cell_index] <= in_item.cell_value;
      else expected_columns.push_back(cast_column(in_item));
    end
    if (!rst_n) start <= 1'b0;
    else if (!start || !busy) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_item <= pending_beats.pop_front();
      end else start <= 1'b0;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        dgr_out_t e;
        e = expected_columns.pop_front();
        if (e !== out_item) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch col %0d: expected %h actual %h",
                                         e.column_out, e, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || start || busy || expected_columns.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_POS_X: cam_pos_x = v[20:0];
      REG_POS_Y: cam_pos_y = v[20:0];
      REG_DIR_X: cam_dir_x = v[18:0];
      REG_DIR_Y: cam_dir_y = v[18:0];
      REG_PLANE_X: cam_plane_x = v[18:0];
      default: cam_plane_y = v[18:0];
    endcase
  endtask

  function automatic dgr_in_t make_write(int idx, int val);
    dgr_in_t t;
    t = '0;
    t.cmd = CMD_WRITE; t.cell_index = 10'(idx); t.cell_value = 4'(val);
    t.screen_column = 10'($urandom);
    return t;
  endfunction

  function automatic dgr_in_t make_cast(int col);
    dgr_in_t t;
    t = 25'($urandom);
    t.cmd = CMD_CAST; t.screen_column = 10'(col);
    return t;
  endfunction

  function automatic int rand_dir();
    return $urandom_range(4) == 0 ? ($urandom_range(1) ? 131072 : -131072)
                                  : int'($urandom_range(262144)) - 131072;
  endfunction

  initial begin
    cam_pos_x = 65536; cam_pos_y = 65536;
    cam_dir_x = 65536; cam_dir_y = 0;
    cam_plane_x = 0; cam_plane_y = 43253;
    foreach (grid_map[i]) grid_map[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: a diagonal of walls, all types, column extremes
    for (int i = 0; i < 16; i++) pending_beats.push_back(make_write(5 + i * 33, i));
    pending_beats.push_back(make_write(1023, 15));
    pending_beats.push_back(make_cast(0));
    pending_beats.push_back(make_cast(639));
    pending_beats.push_back(make_cast(1023));
    pending_beats.push_back(make_cast(320));
    pending_beats.push_back(make_cast(700));
    wait_idle();
    // viewer at the grid extremes: origin and far corner
    cfg_write(REG_POS_X, 0); cfg_write(REG_POS_Y, 0);
    cfg_write(REG_DIR_X, -131072); cfg_write(REG_DIR_Y, 131072);
    cfg_write(REG_PLANE_X, 131072); cfg_write(REG_PLANE_Y, -131072);
    pending_beats.push_back(make_cast(0));
    pending_beats.push_back(make_cast(639));
    wait_idle();
    cfg_write(REG_POS_X, 2097151); cfg_write(REG_POS_Y, 2097151);
    pending_beats.push_back(make_cast(320));
    wait_idle();
    // random phases: walls scattered, viewer anywhere inside the grid
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 57;
        2: send_idle_pct = 14;
        default: send_idle_pct = 0;
      endcase
      cfg_write(REG_POS_X, $urandom_range(7) == 0 ? $urandom : $urandom_range(31 << 16));
      cfg_write(REG_POS_Y, $urandom_range(7) == 0 ? $urandom : $urandom_range(31 << 16));
      cfg_write(REG_DIR_X, rand_dir());
      cfg_write(REG_DIR_Y, rand_dir());
      cfg_write(REG_PLANE_X, rand_dir());
      cfg_write(REG_PLANE_Y, rand_dir());
      for (int n = 0; n < 105; n++) begin
        if ($urandom_range(2) == 0) pending_beats.push_back(make_write($urandom, $urandom));
        else pending_beats.push_back(make_cast($urandom_range(15) == 0 ?
                                               $urandom : $urandom_range(639)));
      end
      wait_idle();
    end
    if (mismatches == 0 && expected_columns.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/dgr_pkg.sv
sv/dgr_ram.sv
sv/dgr_div.sv
sv/dgr_datapath.sv
sv/dgr_ctrl.sv
sv/dda_grid_raycast_column.sv
sim/tb_dda_grid_raycast_column.sv
